// ----- rtl/gpa_pkg.sv -----
// ----------------------------------------------------------------------------
// gpa_pkg
// Shared constants for the gimbal pointing angle pipeline: widths, stage
// counts, the CORDIC arctangent table and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package gpa_pkg;

  localparam int COORD_W       = 32;
  localparam int CORDIC_STAGES = 24;
  localparam int SQRT_STAGES   = 32;
  localparam int ANG_W         = 34;  // binary angle, 2^31 = 180 degrees
  localparam int VEC_W         = 64;  // CORDIC vector width
  localparam int ATIN_W        = 36;  // atan2 operand width
  localparam int ATAN_LAT      = 4 + CORDIC_STAGES;
  localparam int SPEC_DLY      = ATAN_LAT + 1;
  localparam int PIPE_DEPTH    = 3 + SQRT_STAGES + 2 + ATAN_LAT + 1;

  localparam logic signed [ANG_W-1:0] HALF_TURN = 34'sd2147483648;

  localparam logic [7:0] YAW_LIM   = 8'd180;
  localparam logic [7:0] PITCH_LIM = 8'd90;

  // Pitch codes for zero horizontal distance
  localparam logic signed [10:0] PITCH_UP   = 11'sd250;
  localparam logic signed [10:0] PITCH_DOWN = -11'sd900;
  localparam logic signed [10:0] PITCH_FLAT = 11'sd0;

  // Configuration register indexes
  localparam logic REG_HEIGHT = 1'b0;
  localparam logic REG_ARM    = 1'b1;

  // atan(2^-i) in binary angle units, rounded to nearest
  localparam logic signed [ANG_W-1:0] ATAN_LUT [32] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
    34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
    34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
    34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
    34'sd652,       34'sd326,       34'sd163,       34'sd81,
    34'sd41,        34'sd20,        34'sd10,        34'sd5,
    34'sd3,         34'sd1,         34'sd1,         34'sd0
  };

endpackage

`default_nettype wire

// ----- rtl/gpa_isqrt.sv -----
// ----------------------------------------------------------------------------
// gpa_isqrt
// Pipelined integer square root, one result bit per stage. Returns the
// floor root and the remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module gpa_isqrt (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [63:0] rad_i,
  output logic      [63:0] root_o,
  output logic      [63:0] rem_o
);
  import gpa_pkg::*;

  logic [63:0] rem_q  [SQRT_STAGES];
  logic [63:0] root_q [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic [63:0] rem_in;
    logic [63:0] root_in;
    logic [63:0] bit_v;
    logic [63:0] trial;

    if (k == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign bit_v = 64'd1 << (62 - 2*k);
    assign trial = root_in + bit_v;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_in >= trial) begin
          rem_q[k]  <= rem_in - trial;
          root_q[k] <= (root_in >> 1) + bit_v;
        end else begin
          rem_q[k]  <= rem_in;
          root_q[k] <= root_in >> 1;
        end
      end
    end
  end

  assign root_o = root_q[SQRT_STAGES-1];
  assign rem_o  = rem_q[SQRT_STAGES-1];

endmodule

`default_nettype wire

// ----- rtl/gpa_atan2.sv -----
// ----------------------------------------------------------------------------
// gpa_atan2
// Pipelined atan2: half-turn fold, staged normalization to 2^56, then a
// vectoring CORDIC with one rotation per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gpa_atan2 (
  input  wire logic                               clk_i,
  input  wire logic                               en_i,
  input  wire logic signed [gpa_pkg::ATIN_W-1:0]  x_i,
  input  wire logic signed [gpa_pkg::ATIN_W-1:0]  y_i,
  output logic      signed [gpa_pkg::ANG_W-1:0]   ang_o
);
  import gpa_pkg::*;

  // fold stage
  logic signed [ATIN_W-1:0] n0x_q, n0y_q;
  logic signed [ANG_W-1:0]  n0a_q;
  logic                     n0z_q;
  // coarse normalize
  logic signed [ATIN_W-1:0] n1x_q, n1y_q;
  logic signed [ANG_W-1:0]  n1a_q;
  logic                     n1z_q;
  logic [63:0]              n1m_q;
  logic [5:0]               n1sh_q;
  // fine normalize
  logic signed [ATIN_W-1:0] n2x_q, n2y_q;
  logic signed [ANG_W-1:0]  n2a_q;
  logic                     n2z_q;
  logic [5:0]               n2sh_q;
  // shifted vector
  logic signed [VEC_W-1:0]  n3x_q, n3y_q;
  logic signed [ANG_W-1:0]  n3a_q;
  logic                     n3z_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n0z_q <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        n0x_q <= -x_i;
        n0y_q <= -y_i;
        n0a_q <= (y_i >= 0) ? HALF_TURN : -HALF_TURN;
      end else begin
        n0x_q <= x_i;
        n0y_q <= y_i;
        n0a_q <= '0;
      end
    end
  end

  logic [63:0] m1;
  logic [5:0]  sh1;
  always_comb begin
    logic [ATIN_W-1:0] yabs;
    logic [ATIN_W-1:0] xabs;
    yabs = (n0y_q < 0) ? ATIN_W'(-n0y_q) : ATIN_W'(n0y_q);
    xabs = ATIN_W'(n0x_q);
    m1   = {{(64-ATIN_W){1'b0}}, ((xabs > yabs) ? xabs : yabs)};
    sh1  = '0;
    if (m1 < (64'd1 << 25)) begin m1 = m1 << 32; sh1 = sh1 + 6'd32; end
    if (m1 < (64'd1 << 41)) begin m1 = m1 << 16; sh1 = sh1 + 6'd16; end
    if (m1 < (64'd1 << 49)) begin m1 = m1 << 8;  sh1 = sh1 + 6'd8;  end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n1x_q  <= n0x_q;
      n1y_q  <= n0y_q;
      n1a_q  <= n0a_q;
      n1z_q  <= n0z_q;
      n1m_q  <= m1;
      n1sh_q <= sh1;
    end
  end

  logic [5:0] sh2;
  always_comb begin
    logic [63:0] m;
    m   = n1m_q;
    sh2 = n1sh_q;
    if (m < (64'd1 << 53)) begin m = m << 4; sh2 = sh2 + 6'd4; end
    if (m < (64'd1 << 55)) begin m = m << 2; sh2 = sh2 + 6'd2; end
    if (m < (64'd1 << 56)) begin sh2 = sh2 + 6'd1; end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n2x_q  <= n1x_q;
      n2y_q  <= n1y_q;
      n2a_q  <= n1a_q;
      n2z_q  <= n1z_q;
      n2sh_q <= sh2;
    end
  end

  logic signed [VEC_W-1:0] xw, yw;
  assign xw = {{(VEC_W-ATIN_W){n2x_q[ATIN_W-1]}}, n2x_q};
  assign yw = {{(VEC_W-ATIN_W){n2y_q[ATIN_W-1]}}, n2y_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n3x_q <= xw <<< n2sh_q;
      n3y_q <= yw <<< n2sh_q;
      n3a_q <= n2a_q;
      n3z_q <= n2z_q;
    end
  end

  logic signed [VEC_W-1:0] cx_q [CORDIC_STAGES];
  logic signed [VEC_W-1:0] cy_q [CORDIC_STAGES];
  logic signed [ANG_W-1:0] ca_q [CORDIC_STAGES];
  logic                    cz_q [CORDIC_STAGES];

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
    logic signed [VEC_W-1:0] x_in, y_in;
    logic signed [ANG_W-1:0] a_in;
    logic                    z_in;

    if (k == 0) begin : g_first
      assign x_in = n3x_q;
      assign y_in = n3y_q;
      assign a_in = n3a_q;
      assign z_in = n3z_q;
    end else begin : g_next
      assign x_in = cx_q[k-1];
      assign y_in = cy_q[k-1];
      assign a_in = ca_q[k-1];
      assign z_in = cz_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cz_q[k] <= z_in;
        if (y_in >= 0) begin
          cx_q[k] <= x_in + (y_in >>> k);
          cy_q[k] <= y_in - (x_in >>> k);
          ca_q[k] <= a_in + ATAN_LUT[k];
        end else begin
          cx_q[k] <= x_in - (y_in >>> k);
          cy_q[k] <= y_in + (x_in >>> k);
          ca_q[k] <= a_in - ATAN_LUT[k];
        end
      end
    end
  end

  assign ang_o = cz_q[CORDIC_STAGES-1] ? '0 : ca_q[CORDIC_STAGES-1];

endmodule

`default_nettype wire

// ----- rtl/gpa_deg.sv -----
// ----------------------------------------------------------------------------
// gpa_deg
// Binary angle to whole degrees times ten: registered scale by 180, then
// round, clamp, times ten and sign.
// ----------------------------------------------------------------------------
`default_nettype none

module gpa_deg (
  input  wire logic                             clk_i,
  input  wire logic                             en_i,
  input  wire logic signed [gpa_pkg::ANG_W-1:0] ang_i,
  input  wire logic        [7:0]                lim_i,
  output logic      signed [11:0]               tenths_o
);
  import gpa_pkg::*;

  logic [ANG_W-1:0] mag;
  logic [41:0]      prod_q;
  logic             neg_q;

  assign mag = ang_i[ANG_W-1] ? ANG_W'(-ang_i) : ANG_W'(ang_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q  <= ang_i[ANG_W-1];
      prod_q <= {{(42-ANG_W){1'b0}}, mag} * 42'd180 + (42'd1 << 30);
    end
  end

  logic [10:0] q;
  logic [7:0]  qc;
  logic [10:0] t;
  assign q  = prod_q[41:31];
  assign qc = (q > {3'b0, lim_i}) ? lim_i : q[7:0];
  assign t  = {3'b0, qc} * 11'd10;
  assign tenths_o = neg_q ? -$signed({1'b0, t}) : $signed({1'b0, t});

endmodule

`default_nettype wire

// ----- rtl/gimbal_pointing_angles.sv -----
// Throughput: one point per cycle unless the output register holds an untaken
// result; the whole pipeline advances and stalls together.
// Most of the depth comes from the 32-stage square root and the 28-stage atan2 units.
// Reset (rst_ni low, asynchronous) clears all valid bits and both offset registers.
// Payload registers are not reset.
// ----------------------------------------------------------------------------
// gimbal_pointing_angles
// Converts a target point into gimbal yaw and pitch in tenths of a degree.
// Yaw = atan2(y, x); pitch = atan2(z + height, |sqrt(x^2 + y^2) - arm|).
// ----------------------------------------------------------------------------
`default_nettype none

module gimbal_pointing_angles (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration writes
  input  wire logic                                cfg_we_i,
  input  wire logic                                cfg_idx_i,
  input  wire logic [31:0]                         cfg_wdata_i,
  // target point transaction
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [gpa_pkg::COORD_W-1:0]  target_x_i,
  input  wire logic signed [gpa_pkg::COORD_W-1:0]  target_y_i,
  input  wire logic signed [gpa_pkg::COORD_W-1:0]  target_z_i,
  // angle transaction
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [11:0]                       yaw_tenths_o,
  output logic signed [10:0]                       pitch_tenths_o
);
  import gpa_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [31:0] height_q, arm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= '0;
      arm_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HEIGHT: height_q <= cfg_wdata_i;
        REG_ARM:    arm_q    <= cfg_wdata_i;
        default:    ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Global advance: every stage moves unless the output register holds a
  // result nobody has taken. Input ready is this same advance signal.
  // --------------------------------------------------------------------------
  logic en;
  logic out_vld_q;
  logic [PIPE_DEPTH-1:0] vld_q;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[PIPE_DEPTH-2:0], in_valid_i};
      out_vld_q <= vld_q[PIPE_DEPTH-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: magnitudes and elevation sum
  // --------------------------------------------------------------------------
  logic signed [31:0] x1_q, y1_q;
  logic signed [32:0] nz1_q;
  logic [31:0]        ax1_q, ay1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q  <= target_x_i;
      y1_q  <= target_y_i;
      nz1_q <= {target_z_i[31], target_z_i} + {height_q[31], height_q};
      ax1_q <= target_x_i[31] ? 32'(-target_x_i) : 32'(target_x_i);
      ay1_q <= target_y_i[31] ? 32'(-target_y_i) : 32'(target_y_i);
    end
  end

  // Stage 2: squares
  logic signed [31:0] x2_q, y2_q;
  logic signed [32:0] nz2_q;
  logic [63:0]        sqx2_q, sqy2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x2_q   <= x1_q;
      y2_q   <= y1_q;
      nz2_q  <= nz1_q;
      sqx2_q <= {32'b0, ax1_q} * {32'b0, ax1_q};
      sqy2_q <= {32'b0, ay1_q} * {32'b0, ay1_q};
    end
  end

  // Stage 3: radicand (fits in 64 bits, max 2^63)
  logic signed [31:0] x3_q, y3_q;
  logic signed [32:0] nz3_q;
  logic [63:0]        rad3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x3_q   <= x2_q;
      y3_q   <= y2_q;
      nz3_q  <= nz2_q;
      rad3_q <= sqx2_q + sqy2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Horizontal range: pipelined square root, side data delayed alongside
  // --------------------------------------------------------------------------
  logic [63:0] root_w, rem_w;

  gpa_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad3_q),
    .root_o (root_w),
    .rem_o  (rem_w)
  );

  logic signed [31:0] xd_q  [SQRT_STAGES];
  logic signed [31:0] yd_q  [SQRT_STAGES];
  logic signed [32:0] nzd_q [SQRT_STAGES];

  always_ff @(posedge clk_i) begin
    if (en) begin
      xd_q[0]  <= x3_q;
      yd_q[0]  <= y3_q;
      nzd_q[0] <= nz3_q;
      for (int i = 1; i < SQRT_STAGES; i++) begin
        xd_q[i]  <= xd_q[i-1];
        yd_q[i]  <= yd_q[i-1];
        nzd_q[i] <= nzd_q[i-1];
      end
    end
  end

  // Round root to nearest; exact when no remainder
  logic signed [31:0] x36_q, y36_q;
  logic signed [32:0] nz36_q;
  logic [32:0]        r36_q;
  logic               exact36_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x36_q     <= xd_q[SQRT_STAGES-1];
      y36_q     <= yd_q[SQRT_STAGES-1];
      nz36_q    <= nzd_q[SQRT_STAGES-1];
      r36_q     <= root_w[32:0] + {32'b0, (rem_w > root_w)};
      exact36_q <= (rem_w == '0);
    end
  end

  // Distance from the arm circle; an exact zero distance picks a fixed pitch
  logic signed [34:0] diff;
  logic [33:0]        dabs;
  logic               dzero;
  assign diff  = $signed({2'b0, r36_q}) - $signed({{3{arm_q[31]}}, arm_q});
  assign dabs  = diff[34] ? 34'(-diff) : 34'(diff);
  assign dzero = (dabs == '0);

  logic signed [31:0] x37_q, y37_q;
  logic signed [32:0] nz37_q;
  logic [33:0]        d37_q;
  logic               spec37_q;
  logic signed [10:0] specv37_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x37_q    <= x36_q;
      y37_q    <= y36_q;
      nz37_q   <= nz36_q;
      d37_q    <= (dzero && !exact36_q) ? 34'd1 : dabs;
      spec37_q <= dzero && exact36_q;
      if (nz36_q > 0)      specv37_q <= PITCH_UP;
      else if (nz36_q < 0) specv37_q <= PITCH_DOWN;
      else                 specv37_q <= PITCH_FLAT;
    end
  end

  // --------------------------------------------------------------------------
  // Two atan2 units run side by side
  // --------------------------------------------------------------------------
  logic signed [ANG_W-1:0] yaw_ang, pitch_ang;

  gpa_atan2 u_yaw_atan (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   ({{(ATIN_W-32){x37_q[31]}}, x37_q}),
    .y_i   ({{(ATIN_W-32){y37_q[31]}}, y37_q}),
    .ang_o (yaw_ang)
  );

  gpa_atan2 u_pitch_atan (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   ({{(ATIN_W-34){1'b0}}, d37_q}),
    .y_i   ({{(ATIN_W-33){nz37_q[32]}}, nz37_q}),
    .ang_o (pitch_ang)
  );

  logic signed [11:0] yaw_t, pitch_t;

  gpa_deg u_yaw_deg (
    .clk_i    (clk_i),
    .en_i     (en),
    .ang_i    (yaw_ang),
    .lim_i    (YAW_LIM),
    .tenths_o (yaw_t)
  );

  gpa_deg u_pitch_deg (
    .clk_i    (clk_i),
    .en_i     (en),
    .ang_i    (pitch_ang),
    .lim_i    (PITCH_LIM),
    .tenths_o (pitch_t)
  );

  // Zero-distance override travels with the angle data
  logic               sdly_q  [SPEC_DLY];
  logic signed [10:0] svdly_q [SPEC_DLY];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sdly_q[0]  <= spec37_q;
      svdly_q[0] <= specv37_q;
      for (int i = 1; i < SPEC_DLY; i++) begin
        sdly_q[i]  <= sdly_q[i-1];
        svdly_q[i] <= svdly_q[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic signed [11:0] yaw_q;
  logic signed [10:0] pitch_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      yaw_q   <= yaw_t;
      pitch_q <= sdly_q[SPEC_DLY-1] ? svdly_q[SPEC_DLY-1] : pitch_t[10:0];
    end
  end

  assign out_valid_o    = out_vld_q;
  assign yaw_tenths_o   = yaw_q;
  assign pitch_tenths_o = pitch_q;

`ifndef SYNTH
  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (yaw_tenths_o >= -12'sd1800) && (yaw_tenths_o <= 12'sd1800))
    else $error("yaw out of range");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pitch_tenths_o >= -11'sd900) && (pitch_tenths_o <= 11'sd900))
    else $error("pitch out of range");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && !vld_q[PIPE_DEPTH-1]) |=> !out_valid_o)
    else $error("result without a valid item");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved while stalled");
`endif

endmodule

`default_nettype wire

// ----- test/tb_gimbal_pointing_angles.sv -----
// ----------------------------------------------------------------------------
// tb_gimbal_pointing_angles
// Self-checking testbench for the gimbal pointing angle pipeline. It runs a
// directed table of target points, points at a range equal to the arm
// offset, then random points under several offset settings. Expected yaw and
// pitch come from typed rows or a bit-accurate model of the square root and
// CORDIC arithmetic and are compared in order with the angle transactions that leave the block.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_gimbal_pointing_angles;
  import gpa_pkg::*;

  localparam int  LATENCY     = 66;
  localparam int  CYCLE_LIMIT = 1000000;
  localparam logic signed [31:0] CMAX = 32'sh7fffffff;
  localparam logic signed [31:0] CMIN = 32'sh80000000;
  localparam logic signed [31:0] ONE  = 32'sd65536;

  // one row of the directed table; typed rows carry the expected angles
  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    bit                 typed;
    logic signed [11:0] yaw;
    logic signed [10:0] pitch;
  } point_row_t;

  typedef struct {
    logic signed [11:0] yaw;
    logic signed [10:0] pitch;
  } angles_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_idx_i;
  logic [31:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_ready_o;
  logic signed [COORD_W-1:0] target_x_i, target_y_i, target_z_i;
  logic out_valid_o;
  logic out_ready_i;
  logic signed [11:0] yaw_tenths_o;
  logic signed [10:0] pitch_tenths_o;

  // typed expectation travels with the payload, so it is seen at acceptance
  logic               row_typed;
  logic signed [11:0] row_yaw;
  logic signed [10:0] row_pitch;

  // mirror of the offset registers
  longint height_cfg;
  longint arm_cfg;

  angles_t pending_angles [$];
  int      mismatches;
  int      cycles;
  bit      no_idle;  // stretches where neither side idles

  gimbal_pointing_angles DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .target_x_i     (target_x_i),
    .target_y_i     (target_y_i),
    .target_z_i     (target_z_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .yaw_tenths_o   (yaw_tenths_o),
    .pitch_tenths_o (pitch_tenths_o)
  );

  point_row_t point_table [] = '{
    // both operands zero, and zero horizontal distance above, below, level
    '{32'sd0, 32'sd0, 32'sd0,     1'b1, 12'sd0, 11'sd0},
    '{32'sd0, 32'sd0, ONE,        1'b1, 12'sd0, PITCH_UP},
    '{32'sd0, 32'sd0, -ONE,       1'b1, 12'sd0, PITCH_DOWN},
    '{32'sd0, 32'sd0, CMAX,       1'b1, 12'sd0, PITCH_UP},
    '{32'sd0, 32'sd0, CMIN,       1'b1, 12'sd0, PITCH_DOWN},
    // axis points
    '{ONE,    32'sd0, 32'sd0,     1'b1, 12'sd0, 11'sd0},
    '{32'sd0, ONE,    32'sd0,     1'b1, 12'sd900, 11'sd0},
    '{-ONE,   32'sd0, 32'sd0,     1'b1, 12'sd1800, 11'sd0},
    '{32'sd0, -ONE,   32'sd0,     1'b1, -12'sd900, 11'sd0},
    '{-32'sd1, 32'sd0, 32'sd0,    1'b1, 12'sd1800, 11'sd0},
    // extremes and diagonals
    '{CMAX, CMAX, CMAX,           1'b0, 12'sd0, 11'sd0},
    '{CMIN, CMIN, CMIN,           1'b0, 12'sd0, 11'sd0},
    '{CMIN, CMAX, 32'sd0,         1'b0, 12'sd0, 11'sd0},
    '{CMAX, CMIN, CMAX,           1'b0, 12'sd0, 11'sd0},
    '{CMIN, 32'sd0, CMAX,         1'b0, 12'sd0, 11'sd0},
    '{CMIN, -32'sd1, 32'sd0,      1'b0, 12'sd0, 11'sd0},
    '{-32'sd1, -32'sd1, -32'sd1,  1'b0, 12'sd0, 11'sd0},
    '{32'sd1, 32'sd1, 32'sd1,     1'b0, 12'sd0, 11'sd0},
    '{ONE, ONE, ONE,              1'b0, 12'sd0, 11'sd0},
    '{-ONE, -ONE, 32'sd0,         1'b0, 12'sd0, 11'sd0},
    '{32'sd3, 32'sd4, CMIN,       1'b0, 12'sd0, 11'sd0}
  };

  // ---------------------------------------------------------------------------
  // Angle arithmetic, bit for bit
  // ---------------------------------------------------------------------------
  function automatic longint unsigned abs64(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  // vectoring CORDIC, binary angle units (2^31 = 180 degrees)
  function automatic longint cordic_angle(longint x, longint y);
    longint acc;
    longint dx, dy;
    longint unsigned m;
    acc = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      acc = (y >= 0) ? 64'sd2147483648 : -64'sd2147483648;
      x = -x;
      y = -y;
    end
    m = abs64(x) > abs64(y) ? abs64(x) : abs64(y);
    while (m < (64'd1 << 56)) begin
      x = x * 2;
      y = y * 2;
      m = m * 2;
    end
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x   = x + dx;
        y   = y - dy;
        acc = acc + longint'(ATAN_LUT[i]);
      end else begin
        x   = x - dx;
        y   = y + dy;
        acc = acc - longint'(ATAN_LUT[i]);
      end
    end
    return acc;
  endfunction

  // round to whole degrees, clamp, scale by ten
  function automatic longint angle_tenths(longint ang, longint unsigned lim);
    longint unsigned q;
    longint t;
    q = (abs64(ang) * 180 + (64'd1 << 30)) >> 31;
    if (q > lim) q = lim;
    t = longint'(q * 10);
    return ang < 0 ? -t : t;
  endfunction

  function automatic angles_t pointing_angles(logic signed [31:0] x, logic signed [31:0] y,
                                              logic signed [31:0] z);
    angles_t a;
    longint unsigned s, root, bitv, ax, ay;
    longint r, d, nz, yaw, pitch;
    bit exact;
    ax = abs64(longint'(x));
    ay = abs64(longint'(y));
    s = ax * ax + ay * ay;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= root + bitv) begin
        s    = s - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    exact = (s == 0);
    if (s > root) root = root + 1;
    r = longint'(root);
    d = r - arm_cfg;
    if (d < 0) d = -d;
    if (d == 0 && !exact) d = 1;  // near-zero distance counts as one LSB
    yaw = angle_tenths(cordic_angle(longint'(x), longint'(y)), 180);
    nz = longint'(z) + height_cfg;
    if (d == 0) begin
      if (nz > 0)      pitch = PITCH_UP;
      else if (nz < 0) pitch = PITCH_DOWN;
      else             pitch = PITCH_FLAT;
    end else begin
      pitch = angle_tenths(cordic_angle(d, nz), 90);
    end
    a.yaw   = yaw[11:0];
    a.pitch = pitch[10:0];
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_gimbal_pointing_angles failed");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (no_idle || p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure
  // ---------------------------------------------------------------------------
  initial begin
    int n;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      n = idle_len();
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on input transaction, check on angle transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    angles_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        if (row_typed) begin
          want.yaw   = row_yaw;
          want.pitch = row_pitch;
        end else begin
          want = pointing_angles(target_x_i, target_y_i, target_z_i);
        end
        pending_angles.push_back(want);
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_angles.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("unexpected angle transaction yaw=%0d pitch=%0d",
                     yaw_tenths_o, pitch_tenths_o);
        end else begin
          want = pending_angles.pop_front();
          if (yaw_tenths_o !== want.yaw || pitch_tenths_o !== want.pitch) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("mismatch: yaw exp %0d got %0d, pitch exp %0d got %0d",
                       want.yaw, yaw_tenths_o, want.pitch, pitch_tenths_o);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z, bit typed,
                            logic signed [11:0] yaw, logic signed [10:0] pitch);
    int n;
    n = idle_len();
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    target_x_i <= x;
    target_y_i <= y;
    target_z_i <= z;
    row_typed  <= typed;
    row_yaw    <= yaw;
    row_pitch  <= pitch;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // hold the sender until every expected angle has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_angles.size() != 0) @(posedge clk_i);
  endtask

  // one write, then an idle gap so back-to-back writes never collide
  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_HEIGHT) height_cfg = longint'(signed'(val));
    else                   arm_cfg    = longint'(signed'(val));
    @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_coord();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return $urandom();
    if (p < 80) return $signed($urandom_range(0, 2097152)) - 32'sd1048576;
    case ($urandom_range(0, 4))
      0: return CMAX;
      1: return CMIN;
      2: return 32'sd0;
      3: return 32'sd1;
      default: return -32'sd1;
    endcase
  endfunction

  initial begin
    logic signed [31:0] x, y, z;
    logic [31:0] hv, av;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_HEIGHT;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    target_x_i  = '0;
    target_y_i  = '0;
    target_z_i  = '0;
    row_typed   = 1'b0;
    row_yaw     = '0;
    row_pitch   = '0;
    height_cfg  = 0;
    arm_cfg     = 0;
    mismatches  = 0;
    cycles      = 0;
    no_idle     = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at reset offsets
    foreach (point_table[i])
      send_point(point_table[i].x, point_table[i].y, point_table[i].z,
                 point_table[i].typed, point_table[i].yaw, point_table[i].pitch);
    drain();

    // range equal to the arm offset: inexact root (1,1) and exact root (1,0)
    write_reg(REG_ARM, 32'd1);
    send_point(32'sd1, 32'sd1, 32'sd5, 1'b0, '0, '0);
    send_point(32'sd1, 32'sd1, -32'sd5, 1'b0, '0, '0);
    send_point(32'sd1, 32'sd0, 32'sd5, 1'b1, 12'sd0, PITCH_UP);
    send_point(32'sd0, -32'sd1, -32'sd5, 1'b1, -12'sd900, PITCH_DOWN);
    drain();
    write_reg(REG_HEIGHT, -32'sd5);
    send_point(32'sd1, 32'sd0, 32'sd5, 1'b1, 12'sd0, PITCH_FLAT);
    send_point(32'sd3, 32'sd4, 32'sd5, 1'b0, '0, '0);
    drain();

    // random phases, offsets at the extremes and in between
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin hv = 32'h0;        av = 32'h0;        end
        1: begin hv = 32'h80000000; av = 32'h7fffffff; end
        2: begin hv = 32'h7fffffff; av = 32'h80000000; end
        3: begin hv = $urandom_range(0, 2097152) - 1048576;
                 av = $urandom_range(0, 2097152); end
        default: begin hv = $urandom(); av = $urandom(); end
      endcase
      write_reg(REG_HEIGHT, hv);
      write_reg(REG_ARM, av);
      no_idle = (ph == 2);
      for (int k = 0; k < 150; k++) begin
        x = rand_coord();
        y = rand_coord();
        z = rand_coord();
        // some points on the arm circle or straight above or below the pivot
        if ($urandom_range(0, 19) == 0) begin
          if (av[31] == 1'b0 && av < 32'h7fffffff && $urandom_range(0, 1)) begin
            x = av;
            y = 32'sd0;
          end else begin
            x = 32'sd0;
            y = 32'sd0;
          end
        end
        send_point(x, y, z, 1'b0, '0, '0);
      end
      drain();
    end
    no_idle = 1'b0;

    repeat (LATENCY + 20) @(posedge clk_i);
    if (mismatches == 0 && pending_angles.size() == 0) begin
      $display("tb_gimbal_pointing_angles passed");
    end else begin
      $display("tb_gimbal_pointing_angles failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/gpa_pkg.sv
rtl/gpa_isqrt.sv
rtl/gpa_atan2.sv
rtl/gpa_deg.sv
rtl/gimbal_pointing_angles.sv
test/tb_gimbal_pointing_angles.sv
